[hdl/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared constants, the block header layout and the sequencer codes.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int HEAP_WORDS = 16384;    // arena size in 4-byte words
	localparam int IDX_W      = 14;       // header store index width
	localparam int WADDR_W    = 15;       // word address, able to hold the arena top
	localparam int HDR_WORDS  = 5;        // header length in words
	localparam int HDR_BYTES  = 20;       // header length in bytes
	localparam int SPLIT_MIN  = 6;        // smallest leftover worth splitting, in words
	localparam int REQ_W      = 17;       // request size register width

	typedef struct packed {
		logic             vld;
		logic             fre;
		logic             hp;
		logic [IDX_W-1:0] st;
		logic [IDX_W-1:0] sz;
		logic [IDX_W-1:0] pv;
	} hdr_t;

	localparam int HDR_BITS = $bits(hdr_t);

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_RESIZE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOMEM   = 2'd1,
		ST_TOOBIG  = 2'd2,
		ST_BADADDR = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_CHK, S_CHK_D, S_RS_ND, S_RSF, S_RSOK,
		S_ALLOC, S_WALK, S_WALK_D, S_APPEND, S_AOK,
		S_FREE_RD, S_FREE_D, S_FPREV_RD, S_FPREV_D, S_FTAIL,
		S_FUSE, S_FUSE_D, S_FUSE_WB, S_FUSE_ND,
		S_SPLIT, S_SPLIT_WB, S_SPLIT_ND, S_DONE
	} state_t;

	typedef enum logic [2:0] {
		R_AOK, R_RSOK, R_RSF, R_FTAIL, R_FDONE
	} ret_t;

endpackage

[hdl/ffha_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/first_fit_heap_allocator_top.sv]
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Allocate, free and resize requests over a 64 KiB arena of headed blocks.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_axis channel: tuser carries the operation and
// tdata the requested size and the data address. Each item gives exactly one
// result on m_axis: the granted address, a status code and a moved flag.
// The block works on one item at a time. All block headers live in one
// synchronous RAM with a registered read, and every header access is a
// separate read or write step of the sequencer. An allocation walks the
// header chain first-fit and appends at the break when no free block fits;
// a free or a resize reads the headers it needs, and a split or a merge
// adds header writes. The first-fit walk over the header chain dominates.
// After reset the header RAM is swept clear, one entry a cycle, and
// s_axis_tready stays low meanwhile. max_request may be
// written during the sweep. A finished result waits in an output register
// while the next item is taken; if that register is still full when the
// following result is ready, the sequencer holds until m_axis_tready.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        max_request_wr_en,
	input  logic [16:0] max_request_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // req_bytes[15:0], user_addr[31:16]
	input  logic [1:0]  s_axis_tuser,   // op[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // result_addr[15:0], status[17:16], moved[18]
);

	localparam int IW = ffha_pkg::IDX_W;
	localparam int WW = ffha_pkg::WADDR_W;

	ffha_pkg::state_t state_q, state_d;
	ffha_pkg::ret_t   ret_q, ret_d;

	logic [1:0]  op_q, op_d;
	logic [15:0] req_q, req_d;
	logic [15:0] v_q, v_d;
	logic [16:0] nb_q, nb_d;
	logic        mv_q, mv_d;
	logic [WW-1:0] a_q, a_d;
	logic [WW-1:0] s_q, s_d;
	logic [15:0] n_q, n_d;
	logic [15:0] t_q, t_d;
	logic [IW-1:0] last_q, last_d;
	logic        hl_q, hl_d;
	logic [IW-1:0] start_q, start_d;
	ffha_pkg::hdr_t b_q, b_d;
	logic [WW-1:0] brk_q, brk_d;
	logic        ne_q, ne_d;
	logic [16:0] maxreq_q;
	logic [IW-1:0] clr_q, clr_d;
	logic [15:0] res_addr_q, res_addr_d;
	ffha_pkg::status_t res_st_q, res_st_d;
	logic        res_mv_q, res_mv_d;
	logic        out_vld_q, out_vld_d;
	logic [18:0] out_data_q, out_data_d;

	logic          mem_we, mem_re;
	logic [IW-1:0] mem_waddr, mem_raddr;
	ffha_pkg::hdr_t mem_wdata, rd;
	logic [ffha_pkg::HDR_BITS-1:0] rd_bits;

	logic [15:0] brk16, vm20, nxt_b, nxt_r, na_s, fused_sz;
	logic [WW-1:0] s_req, s_nb;
	logic [16:0] top_s;
	logic          adr_pre;

	ffha_ram #(.WIDTH(ffha_pkg::HDR_BITS), .DEPTH(ffha_pkg::HEAP_WORDS)) u_hdr_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_bits)
	);

	assign rd = ffha_pkg::hdr_t'(rd_bits);

	assign brk16    = {1'b0, brk_q};
	assign vm20     = v_q - 16'(ffha_pkg::HDR_BYTES);
	assign nxt_b    = {1'b0, a_q} + 16'(ffha_pkg::HDR_WORDS) + {2'b00, b_q.sz};
	assign nxt_r    = {1'b0, a_q} + 16'(ffha_pkg::HDR_WORDS) + {2'b00, rd.sz};
	assign na_s     = {1'b0, a_q} + 16'(ffha_pkg::HDR_WORDS) + {1'b0, s_q};
	assign fused_sz = {2'b00, b_q.sz} + 16'(ffha_pkg::HDR_WORDS) + {2'b00, rd.sz};
	assign s_req    = WW'(({2'b00, req_q} + 18'd3) >> 2);
	assign s_nb     = WW'(({1'b0, nb_q} + 18'd3) >> 2);
	assign top_s    = {2'b00, brk_q} + 17'(ffha_pkg::HDR_WORDS) + {2'b00, s_q};
	// Data address must sit just above a header inside the used arena.
	assign adr_pre  = ne_q && (v_q != 16'd0) && (v_q >= 16'(ffha_pkg::HDR_BYTES)) &&
	                  ({1'b0, v_q} < {brk_q, 2'b00}) && (vm20[1:0] == 2'b00);

	assign s_axis_tready = (state_q == ffha_pkg::S_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {5'd0, out_data_q};

	function automatic ffha_pkg::state_t ret_state(input ffha_pkg::ret_t r);
		case (r)
			ffha_pkg::R_AOK:   ret_state = ffha_pkg::S_AOK;
			ffha_pkg::R_RSOK:  ret_state = ffha_pkg::S_RSOK;
			ffha_pkg::R_RSF:   ret_state = ffha_pkg::S_RSF;
			ffha_pkg::R_FTAIL: ret_state = ffha_pkg::S_FTAIL;
			ffha_pkg::R_FDONE: ret_state = ffha_pkg::S_DONE;
			default:           ret_state = ffha_pkg::S_DONE;
		endcase
	endfunction

	always_comb begin
		state_d    = state_q;
		ret_d      = ret_q;
		op_d       = op_q;
		req_d      = req_q;
		v_d        = v_q;
		nb_d       = nb_q;
		mv_d       = mv_q;
		a_d        = a_q;
		s_d        = s_q;
		n_d        = n_q;
		t_d        = t_q;
		last_d     = last_q;
		hl_d       = hl_q;
		start_d    = start_q;
		b_d        = b_q;
		brk_d      = brk_q;
		ne_d       = ne_q;
		clr_d      = clr_q;
		res_addr_d = res_addr_q;
		res_st_d   = res_st_q;
		res_mv_d   = res_mv_q;
		out_vld_d  = out_vld_q;
		out_data_d = out_data_q;
		mem_we     = 1'b0;
		mem_waddr  = a_q[IW-1:0];
		mem_wdata  = b_q;
		mem_re     = 1'b0;
		mem_raddr  = a_q[IW-1:0];

		if (out_vld_q && m_axis_tready) begin
			out_vld_d = 1'b0;
		end

		case (state_q)
			ffha_pkg::S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				clr_d     = clr_q + IW'(1);
				if (clr_q == '1) begin
					state_d = ffha_pkg::S_IDLE;
				end
			end
			ffha_pkg::S_IDLE: begin
				if (s_axis_tvalid) begin
					op_d       = s_axis_tuser;
					req_d      = s_axis_tdata[15:0];
					v_d        = s_axis_tdata[31:16];
					nb_d       = {1'b0, s_axis_tdata[15:0]};
					mv_d       = 1'b0;
					res_addr_d = '0;
					res_st_d   = ffha_pkg::ST_OK;
					res_mv_d   = 1'b0;
					case (ffha_pkg::op_t'(s_axis_tuser))
						ffha_pkg::OP_ALLOC:  state_d = ffha_pkg::S_ALLOC;
						ffha_pkg::OP_FREE:   state_d = ffha_pkg::S_CHK;
						ffha_pkg::OP_RESIZE: begin
							if (s_axis_tdata[31:16] == 16'd0) begin
								state_d = ffha_pkg::S_ALLOC;
							end else begin
								state_d = ffha_pkg::S_CHK;
							end
						end
						default: begin
							res_st_d = ffha_pkg::ST_BADADDR;
							state_d  = ffha_pkg::S_DONE;
						end
					endcase
				end
			end
			ffha_pkg::S_CHK: begin
				if (adr_pre) begin
					mem_re    = 1'b1;
					mem_raddr = vm20[15:2];
					a_d       = {1'b0, vm20[15:2]};
					state_d   = ffha_pkg::S_CHK_D;
				end else begin
					res_st_d = ffha_pkg::ST_BADADDR;
					state_d  = ffha_pkg::S_DONE;
				end
			end
			ffha_pkg::S_CHK_D: begin
				if (!rd.vld || rd.fre || (rd.st != a_q[IW-1:0])) begin
					res_st_d = ffha_pkg::ST_BADADDR;
					state_d  = ffha_pkg::S_DONE;
				end else if (ffha_pkg::op_t'(op_q) == ffha_pkg::OP_FREE) begin
					state_d = ffha_pkg::S_FREE_RD;
				end else begin
					b_d = rd;
					s_d = s_req;
					if ({1'b0, rd.sz} >= s_req) begin
						if (({1'b0, rd.sz} - s_req) >= WW'(ffha_pkg::SPLIT_MIN)) begin
							ret_d   = ffha_pkg::R_RSOK;
							state_d = ffha_pkg::S_SPLIT;
						end else begin
							state_d = ffha_pkg::S_RSOK;
						end
					end else if (nxt_r < brk16) begin
						mem_re    = 1'b1;
						mem_raddr = nxt_r[IW-1:0];
						state_d   = ffha_pkg::S_RS_ND;
					end else begin
						nb_d    = {s_req, 2'b00};
						mv_d    = 1'b1;
						state_d = ffha_pkg::S_ALLOC;
					end
				end
			end
			ffha_pkg::S_RS_ND: begin
				if (rd.fre && (fused_sz >= {1'b0, s_q})) begin
					ret_d   = ffha_pkg::R_RSF;
					state_d = ffha_pkg::S_FUSE;
				end else begin
					nb_d    = {s_q, 2'b00};
					mv_d    = 1'b1;
					state_d = ffha_pkg::S_ALLOC;
				end
			end
			ffha_pkg::S_RSF: begin
				if (({1'b0, b_q.sz} - s_q) >= WW'(ffha_pkg::SPLIT_MIN)) begin
					ret_d   = ffha_pkg::R_RSOK;
					state_d = ffha_pkg::S_SPLIT;
				end else begin
					state_d = ffha_pkg::S_RSOK;
				end
			end
			ffha_pkg::S_RSOK: begin
				res_addr_d = v_q;
				state_d    = ffha_pkg::S_DONE;
			end
			ffha_pkg::S_ALLOC: begin
				if (nb_q >= maxreq_q) begin
					res_st_d = ffha_pkg::ST_TOOBIG;
					state_d  = ffha_pkg::S_DONE;
				end else begin
					s_d     = s_nb;
					a_d     = '0;
					hl_d    = 1'b0;
					last_d  = '0;
					state_d = ffha_pkg::S_WALK;
				end
			end
			ffha_pkg::S_WALK: begin
				if (ne_q && (a_q < brk_q)) begin
					mem_re  = 1'b1;
					state_d = ffha_pkg::S_WALK_D;
				end else begin
					state_d = ffha_pkg::S_APPEND;
				end
			end
			ffha_pkg::S_WALK_D: begin
				if (rd.fre && ({1'b0, rd.sz} >= s_q)) begin
					start_d   = a_q[IW-1:0];
					b_d       = rd;
					b_d.fre   = 1'b0;
					if (({1'b0, rd.sz} - s_q) >= WW'(ffha_pkg::SPLIT_MIN)) begin
						ret_d   = ffha_pkg::R_AOK;
						state_d = ffha_pkg::S_SPLIT;
					end else begin
						mem_we        = 1'b1;
						mem_wdata     = rd;
						mem_wdata.fre = 1'b0;
						state_d       = ffha_pkg::S_AOK;
					end
				end else begin
					last_d  = a_q[IW-1:0];
					hl_d    = 1'b1;
					a_d     = nxt_r[WW-1:0];
					state_d = ffha_pkg::S_WALK;
				end
			end
			ffha_pkg::S_APPEND: begin
				if (top_s > 17'(ffha_pkg::HEAP_WORDS)) begin
					res_st_d = ffha_pkg::ST_NOMEM;
					state_d  = ffha_pkg::S_DONE;
				end else begin
					mem_we        = 1'b1;
					mem_waddr     = brk_q[IW-1:0];
					mem_wdata.vld = 1'b1;
					mem_wdata.fre = 1'b0;
					mem_wdata.hp  = hl_q;
					mem_wdata.st  = brk_q[IW-1:0];
					mem_wdata.sz  = s_q[IW-1:0];
					mem_wdata.pv  = last_q;
					brk_d         = top_s[WW-1:0];
					ne_d          = 1'b1;
					start_d       = brk_q[IW-1:0];
					state_d       = ffha_pkg::S_AOK;
				end
			end
			ffha_pkg::S_AOK: begin
				res_addr_d = {start_q, 2'b00} + 16'(ffha_pkg::HDR_BYTES);
				if (mv_q) begin
					// The old block is released once the new one is granted.
					res_mv_d = 1'b1;
					a_d      = {1'b0, vm20[15:2]};
					state_d  = ffha_pkg::S_FREE_RD;
				end else begin
					state_d = ffha_pkg::S_DONE;
				end
			end
			ffha_pkg::S_FREE_RD: begin
				mem_re  = 1'b1;
				state_d = ffha_pkg::S_FREE_D;
			end
			ffha_pkg::S_FREE_D: begin
				b_d           = rd;
				b_d.fre       = 1'b1;
				mem_we        = 1'b1;
				mem_wdata     = rd;
				mem_wdata.fre = 1'b1;
				state_d       = rd.hp ? ffha_pkg::S_FPREV_RD : ffha_pkg::S_FTAIL;
			end
			ffha_pkg::S_FPREV_RD: begin
				mem_re    = 1'b1;
				mem_raddr = b_q.pv;
				state_d   = ffha_pkg::S_FPREV_D;
			end
			ffha_pkg::S_FPREV_D: begin
				if (rd.fre) begin
					a_d     = {1'b0, b_q.pv};
					b_d     = rd;
					ret_d   = ffha_pkg::R_FTAIL;
					state_d = ffha_pkg::S_FUSE;
				end else begin
					state_d = ffha_pkg::S_FTAIL;
				end
			end
			ffha_pkg::S_FTAIL: begin
				if (nxt_b < brk16) begin
					ret_d   = ffha_pkg::R_FDONE;
					state_d = ffha_pkg::S_FUSE;
				end else begin
					// The freed block is the top one: lower the break instead.
					if (!b_q.hp) begin
						ne_d = 1'b0;
					end
					mem_we        = 1'b1;
					mem_wdata.vld = 1'b0;
					brk_d         = a_q;
					state_d       = ffha_pkg::S_DONE;
				end
			end
			ffha_pkg::S_FUSE: begin
				if (nxt_b < brk16) begin
					mem_re    = 1'b1;
					mem_raddr = nxt_b[IW-1:0];
					n_d       = nxt_b;
					state_d   = ffha_pkg::S_FUSE_D;
				end else begin
					state_d = ret_state(ret_q);
				end
			end
			ffha_pkg::S_FUSE_D: begin
				if (rd.fre) begin
					b_d.sz        = fused_sz[IW-1:0];
					mem_we        = 1'b1;
					mem_waddr     = n_q[IW-1:0];
					mem_wdata     = rd;
					mem_wdata.vld = 1'b0;
					state_d       = ffha_pkg::S_FUSE_WB;
				end else begin
					state_d = ret_state(ret_q);
				end
			end
			ffha_pkg::S_FUSE_WB: begin
				mem_we = 1'b1;
				if (nxt_b < brk16) begin
					mem_re    = 1'b1;
					mem_raddr = nxt_b[IW-1:0];
					t_d       = nxt_b;
					state_d   = ffha_pkg::S_FUSE_ND;
				end else begin
					state_d = ret_state(ret_q);
				end
			end
			ffha_pkg::S_FUSE_ND: begin
				mem_we       = 1'b1;
				mem_waddr    = t_q[IW-1:0];
				mem_wdata    = rd;
				mem_wdata.hp = 1'b1;
				mem_wdata.pv = a_q[IW-1:0];
				state_d      = ret_state(ret_q);
			end
			ffha_pkg::S_SPLIT: begin
				mem_we        = 1'b1;
				mem_waddr     = na_s[IW-1:0];
				mem_wdata.vld = 1'b1;
				mem_wdata.fre = 1'b1;
				mem_wdata.hp  = 1'b1;
				mem_wdata.st  = na_s[IW-1:0];
				mem_wdata.sz  = b_q.sz - s_q[IW-1:0] - IW'(ffha_pkg::HDR_WORDS);
				mem_wdata.pv  = a_q[IW-1:0];
				n_d           = na_s;
				t_d           = nxt_b;
				b_d.sz        = s_q[IW-1:0];
				state_d       = ffha_pkg::S_SPLIT_WB;
			end
			ffha_pkg::S_SPLIT_WB: begin
				mem_we = 1'b1;
				if (t_q < brk16) begin
					mem_re    = 1'b1;
					mem_raddr = t_q[IW-1:0];
					state_d   = ffha_pkg::S_SPLIT_ND;
				end else begin
					state_d = ret_state(ret_q);
				end
			end
			ffha_pkg::S_SPLIT_ND: begin
				mem_we       = 1'b1;
				mem_waddr    = t_q[IW-1:0];
				mem_wdata    = rd;
				mem_wdata.hp = 1'b1;
				mem_wdata.pv = n_q[IW-1:0];
				state_d      = ret_state(ret_q);
			end
			ffha_pkg::S_DONE: begin
				if (!out_vld_q || m_axis_tready) begin
					out_vld_d  = 1'b1;
					out_data_d = {res_mv_q, res_st_q, res_addr_q};
					state_d    = ffha_pkg::S_IDLE;
				end
			end
			default: state_d = ffha_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ffha_pkg::S_CLEAR;
			ret_q     <= ffha_pkg::R_FDONE;
			brk_q     <= '0;
			ne_q      <= 1'b0;
			clr_q     <= '0;
			out_vld_q <= 1'b0;
			maxreq_q  <= 17'h10000;
		end else begin
			state_q   <= state_d;
			ret_q     <= ret_d;
			brk_q     <= brk_d;
			ne_q      <= ne_d;
			clr_q     <= clr_d;
			out_vld_q <= out_vld_d;
			if (max_request_wr_en) begin
				maxreq_q <= max_request_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q       <= op_d;
		req_q      <= req_d;
		v_q        <= v_d;
		nb_q       <= nb_d;
		mv_q       <= mv_d;
		a_q        <= a_d;
		s_q        <= s_d;
		n_q        <= n_d;
		t_q        <= t_d;
		last_q     <= last_d;
		hl_q       <= hl_d;
		start_q    <= start_d;
		b_q        <= b_d;
		res_addr_q <= res_addr_d;
		res_st_q   <= res_st_d;
		res_mv_q   <= res_mv_d;
		out_data_q <= out_data_d;
	end

`ifndef SYNTHESIS
	a_brk_in_arena: assert property (@(posedge clk) disable iff (!arst_n)
		brk_q <= WW'(ffha_pkg::HEAP_WORDS))
		else $error("break beyond the arena");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && (mem_waddr == mem_raddr)))
		else $error("header read and write to the same entry in one cycle");

	a_done_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffha_pkg::S_DONE && state_d == ffha_pkg::S_IDLE) |=> m_axis_tvalid)
		else $error("finished item did not reach the output register");

	a_idle_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffha_pkg::S_CLEAR && clr_q != '1) |=> !s_axis_tready)
		else $error("input taken during the header clearing sweep");
`endif

endmodule

[tb/sv/first_fit_heap_allocator_top_tb.sv]
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives allocate, free and resize requests, some directed and many random,
// predicts every result with a behavioural model of the arena and compares
// each returned item field by field, under random idling on both sides and
// several max_request settings.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	localparam int ARENA_BYTES = 65536;
	localparam int ARENA_WORDS = 16384;
	localparam int STALL_LIMIT = 60000;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] req_bytes;
		logic [15:0] user_addr;
	} request_t;

	typedef struct {
		logic [15:0]       addr;
		ffha_pkg::status_t status;
		logic              moved;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        max_request_wr_en = 1'b0;
	logic [16:0] max_request_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // req_bytes[15:0], user_addr[31:16]
	logic [1:0]  s_axis_tuser = '0;   // op[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // result_addr[15:0], status[17:16], moved[18]

	first_fit_heap_allocator_top i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.max_request_wr_en   (max_request_wr_en),
		.max_request_wr_data (max_request_wr_data),
		.s_axis_tvalid       (s_axis_tvalid),
		.s_axis_tready       (s_axis_tready),
		.s_axis_tdata        (s_axis_tdata),
		.s_axis_tuser        (s_axis_tuser),
		.m_axis_tvalid       (m_axis_tvalid),
		.m_axis_tready       (m_axis_tready),
		.m_axis_tdata        (m_axis_tdata)
	);

	always #5 clk = ~clk;

	request_t pending_requests[$];
	grant_t   expected_grants[$];
	int       live_addrs[$];
	request_t in_flight;
	int       sender_idle_pct = 37;
	int       receiver_idle_pct = 54;
	int       error_count = 0;
	int       stall_cycles = 0;

	// Arena shadow: one header slot per 4-byte word.
	bit hdr_valid[ARENA_WORDS];
	bit hdr_free[ARENA_WORDS];
	bit hdr_has_prev[ARENA_WORDS];
	int hdr_start[ARENA_WORDS];
	int hdr_size[ARENA_WORDS];
	int hdr_prev[ARENA_WORDS];
	int arena_break = 0;
	bit arena_used = 1'b0;
	int size_limit = 65536;

	function automatic bit in_arena(int a);
		return (a >> 2) < ARENA_WORDS;
	endfunction

	function automatic int size_at(int a);
		return in_arena(a) ? hdr_size[a >> 2] : 0;
	endfunction

	function automatic bit free_at(int a);
		return in_arena(a) ? hdr_free[a >> 2] : 1'b0;
	endfunction

	function automatic int block_after(int a);
		return a + ffha_pkg::HDR_BYTES + size_at(a);
	endfunction

	function automatic void link_prev(int a, int p);
		if (in_arena(a)) begin
			hdr_has_prev[a >> 2] = 1'b1;
			hdr_prev[a >> 2] = p;
		end
	endfunction

	function automatic void carve_block(int a, int s);
		int na;
		na = a + ffha_pkg::HDR_BYTES + s;
		if (in_arena(na)) begin
			hdr_valid[na >> 2] = 1'b1;
			hdr_free[na >> 2] = 1'b1;
			hdr_start[na >> 2] = na;
			hdr_size[na >> 2] = size_at(a) - s - ffha_pkg::HDR_BYTES;
			hdr_has_prev[na >> 2] = 1'b1;
			hdr_prev[na >> 2] = a;
		end
		if (in_arena(a))
			hdr_size[a >> 2] = s;
		if (block_after(na) < arena_break)
			link_prev(block_after(na), na);
	endfunction

	function automatic void merge_next(int a);
		int na;
		na = block_after(a);
		if (na < arena_break && free_at(na)) begin
			if (in_arena(a))
				hdr_size[a >> 2] += ffha_pkg::HDR_BYTES + size_at(na);
			if (in_arena(na))
				hdr_valid[na >> 2] = 1'b0;
			if (block_after(a) < arena_break)
				link_prev(block_after(a), a);
		end
	endfunction

	function automatic bit place_block(int n, output int start,
			output ffha_pkg::status_t st);
		int s, a, last;
		bit have_last;
		s = ((n + 3) >> 2) << 2;
		a = 0;
		last = 0;
		have_last = 1'b0;
		start = 0;
		if (n >= size_limit) begin
			st = ffha_pkg::ST_TOOBIG;
			return 1'b0;
		end
		while (arena_used && a < arena_break) begin
			if (free_at(a) && size_at(a) >= s) begin
				if (size_at(a) - s >= ffha_pkg::HDR_BYTES + 4)
					carve_block(a, s);
				hdr_free[a >> 2] = 1'b0;
				start = a;
				st = ffha_pkg::ST_OK;
				return 1'b1;
			end
			last = a;
			have_last = 1'b1;
			a = block_after(a);
		end
		if (ARENA_BYTES - arena_break < ffha_pkg::HDR_BYTES + s) begin
			st = ffha_pkg::ST_NOMEM;
			return 1'b0;
		end
		a = arena_break;
		hdr_valid[a >> 2] = 1'b1;
		hdr_free[a >> 2] = 1'b0;
		hdr_start[a >> 2] = a;
		hdr_size[a >> 2] = s;
		hdr_has_prev[a >> 2] = have_last;
		hdr_prev[a >> 2] = have_last ? last : 0;
		arena_break = a + ffha_pkg::HDR_BYTES + s;
		arena_used = 1'b1;
		start = a;
		st = ffha_pkg::ST_OK;
		return 1'b1;
	endfunction

	function automatic bit owns_block(int v);
		int a;
		if (!arena_used || v == 0 || v >= arena_break || v < ffha_pkg::HDR_BYTES)
			return 1'b0;
		a = v - ffha_pkg::HDR_BYTES;
		return hdr_valid[a >> 2] && hdr_start[a >> 2] == a && !hdr_free[a >> 2];
	endfunction

	function automatic void release_block(int v);
		int a;
		a = v - ffha_pkg::HDR_BYTES;
		hdr_free[a >> 2] = 1'b1;
		if (hdr_has_prev[a >> 2] && free_at(hdr_prev[a >> 2])) begin
			a = hdr_prev[a >> 2];
			merge_next(a);
		end
		if (block_after(a) < arena_break) begin
			merge_next(a);
		end else begin
			if (!hdr_has_prev[a >> 2])
				arena_used = 1'b0;
			hdr_valid[a >> 2] = 1'b0;
			arena_break = a;
		end
	endfunction

	function automatic void drop_live(int v);
		foreach (live_addrs[i])
			if (live_addrs[i] == v) begin
				live_addrs.delete(i);
				return;
			end
	endfunction

	// Works out the grant for one accepted request and updates the arena.
	function automatic void serve_request(request_t r);
		grant_t g;
		int v, s, a, start;
		ffha_pkg::status_t st;
		g.addr = '0;
		g.status = ffha_pkg::ST_OK;
		g.moved = 1'b0;
		v = r.user_addr;
		if (r.op == ffha_pkg::OP_ALLOC || (r.op == ffha_pkg::OP_RESIZE && v == 0)) begin
			if (place_block(r.req_bytes, start, st)) begin
				g.addr = 16'(start + ffha_pkg::HDR_BYTES);
				live_addrs.push_back(start + ffha_pkg::HDR_BYTES);
			end
			g.status = st;
		end else if (r.op == ffha_pkg::OP_FREE) begin
			if (owns_block(v)) begin
				release_block(v);
				drop_live(v);
			end else begin
				g.status = ffha_pkg::ST_BADADDR;
			end
		end else if (r.op == ffha_pkg::OP_RESIZE) begin
			if (!owns_block(v)) begin
				g.status = ffha_pkg::ST_BADADDR;
			end else begin
				s = ((int'(r.req_bytes) + 3) >> 2) << 2;
				a = v - ffha_pkg::HDR_BYTES;
				if (size_at(a) >= s) begin
					if (size_at(a) - s >= ffha_pkg::HDR_BYTES + 4)
						carve_block(a, s);
					g.addr = 16'(v);
				end else if (block_after(a) < arena_break && free_at(block_after(a)) &&
						size_at(a) + ffha_pkg::HDR_BYTES + size_at(block_after(a)) >= s) begin
					merge_next(a);
					if (size_at(a) - s >= ffha_pkg::HDR_BYTES + 4)
						carve_block(a, s);
					g.addr = 16'(v);
				end else if (place_block(s, start, st)) begin
					release_block(v);
					drop_live(v);
					live_addrs.push_back(start + ffha_pkg::HDR_BYTES);
					g.addr = 16'(start + ffha_pkg::HDR_BYTES);
					g.moved = 1'b1;
				end else begin
					g.status = st;
				end
			end
		end else begin
			g.status = ffha_pkg::ST_BADADDR;
		end
		expected_grants.push_back(g);
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		error_count++;
	endtask

	// Request driver.
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			serve_request(in_flight);
		if (!s_axis_tvalid || s_axis_tready) begin
			if (arst_n && pending_requests.size() > 0 &&
					$urandom_range(99) >= sender_idle_pct) begin
				in_flight = pending_requests.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {in_flight.user_addr, in_flight.req_bytes};
				s_axis_tuser <= in_flight.op;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		grant_t g;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_grants.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
			end else begin
				g = expected_grants.pop_front();
				if (m_axis_tdata[15:0] !== g.addr)
					report_mismatch($sformatf("result_addr %0d, expected %0d",
						m_axis_tdata[15:0], g.addr));
				if (m_axis_tdata[17:16] !== g.status)
					report_mismatch($sformatf("status %0d, expected %s",
						m_axis_tdata[17:16], g.status.name()));
				if (m_axis_tdata[18] !== g.moved)
					report_mismatch($sformatf("moved %b, expected %b",
						m_axis_tdata[18], g.moved));
			end
		end
		m_axis_tready <= arst_n && ($urandom_range(99) >= receiver_idle_pct);
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic queue_request(input logic [1:0] op, input int req, input int addr);
		request_t r;
		r.op = op;
		r.req_bytes = 16'(req);
		r.user_addr = 16'(addr);
		while (pending_requests.size() >= 2)
			@(posedge clk);
		pending_requests.push_back(r);
	endtask

	task automatic wait_drained();
		while (pending_requests.size() > 0 || s_axis_tvalid || expected_grants.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_size_limit(input int value);
		wait_drained();
		@(posedge clk);
		max_request_wr_en <= 1'b1;
		max_request_wr_data <= 17'(value);
		size_limit = value;
		@(posedge clk);
		max_request_wr_en <= 1'b0;
	endtask

	function automatic int pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(64);
		else if (r < 90)
			return $urandom_range(1024);
		else if (r < 97)
			return $urandom_range(20000, 1024);
		return $urandom_range(65535);
	endfunction

	function automatic int pick_addr();
		int r;
		r = $urandom_range(99);
		if (live_addrs.size() > 0 && r < 80)
			return live_addrs[$urandom_range(live_addrs.size() - 1)];
		if (live_addrs.size() > 0 && r < 90)
			return live_addrs[$urandom_range(live_addrs.size() - 1)] + $urandom_range(8) - 4;
		return $urandom_range(65535);
	endfunction

	task automatic random_requests(input int count);
		int r;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 40)
				queue_request(ffha_pkg::OP_ALLOC, pick_size(), 0);
			else if (r < 70)
				queue_request(ffha_pkg::OP_FREE, $urandom_range(65535), pick_addr());
			else if (r < 95)
				queue_request(ffha_pkg::OP_RESIZE, pick_size(),
					$urandom_range(9) == 0 ? 0 : pick_addr());
			else
				queue_request(2'($urandom_range(3)), $urandom_range(65535), $urandom_range(65535));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		set_size_limit(65536);

		// Zero-size top block, whose data address equals the break.
		queue_request(ffha_pkg::OP_ALLOC, 0, 0);
		queue_request(ffha_pkg::OP_FREE, 0, 20);
		queue_request(ffha_pkg::OP_ALLOC, 1, 0);
		queue_request(ffha_pkg::OP_ALLOC, 100, 0);
		queue_request(ffha_pkg::OP_ALLOC, 8, 0);
		queue_request(ffha_pkg::OP_FREE, 0, 40);
		// Frees an address that does not head a block, so it is refused.
		queue_request(ffha_pkg::OP_FREE, 0, 64);
		queue_request(ffha_pkg::OP_RESIZE, 4, 184);
		queue_request(ffha_pkg::OP_RESIZE, 200, 184);
		queue_request(ffha_pkg::OP_ALLOC, 40, 0);
		queue_request(ffha_pkg::OP_RESIZE, 60, 40);
		queue_request(ffha_pkg::OP_RESIZE, 0, 0);
		queue_request(ffha_pkg::OP_RESIZE, 12, 41);
		queue_request(ffha_pkg::OP_FREE, 0, 212);
		queue_request(ffha_pkg::OP_FREE, 0, 212);
		queue_request(ffha_pkg::OP_FREE, 0, 0);
		queue_request(OP_UNKNOWN, 16'hFFFF, 16'hFFFF);
		queue_request(ffha_pkg::OP_ALLOC, 65535, 0);
		queue_request(ffha_pkg::OP_ALLOC, 40000, 0);
		queue_request(ffha_pkg::OP_RESIZE, 65535, 40);
		queue_request(ffha_pkg::OP_FREE, 16'hFFFF, 16'hFFFF);
		random_requests(230);

		// Hold the sender until the block has caught up.
		wait_drained();
		set_size_limit(1);
		queue_request(ffha_pkg::OP_ALLOC, 0, 0);
		queue_request(ffha_pkg::OP_ALLOC, 1, 0);
		random_requests(20);

		sender_idle_pct = 54;
		receiver_idle_pct = 37;
		set_size_limit(3000);
		random_requests(200);

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		set_size_limit(65536);
		random_requests(150);

		wait_drained();
		repeat (200) @(posedge clk);
		if (error_count == 0 && expected_grants.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/ffha_pkg.sv
hdl/ffha_ram.sv
hdl/first_fit_heap_allocator_top.sv
tb/sv/first_fit_heap_allocator_top_tb.sv
